// ===== design/bps_pkg.sv =====
// ---------------------------------------------------------------------------
// bps_pkg: shared types and constants
// Field widths, the register reset value and the sequencer states used by
// the best-parent-set subset max block.
// ---------------------------------------------------------------------------
package bps_pkg;

   localparam int SCORE_W   = 32;  // Q16.16 signed score
   localparam int OUT_IDX_W = 15;  // width of set_index and best_set on the ports
   localparam int VARS_W    = 5;   // width of the vars_in_use register

   localparam logic [VARS_W-1:0] VARS_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== design/bps_ram.sv =====
// ---------------------------------------------------------------------------
// bps_ram: simple dual-port synchronous memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module bps_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 47
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bps_core.sv =====
// ---------------------------------------------------------------------------
// bps_core: subset scan sequencer and result register
// Walks the set bits of one parent set low to high, reads the stored best of
// each one-bit-smaller subset, keeps the running best and writes it back.
// ---------------------------------------------------------------------------
module bps_core #(
   parameter int IDX_W = 15
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [bps_pkg::SCORE_W-1:0]     req_local_score,
   input  logic [IDX_W-1:0]                       set_ps,
   input  logic                                   set_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [bps_pkg::OUT_IDX_W-1:0]          rsp_set_index,
   output logic [bps_pkg::OUT_IDX_W-1:0]          rsp_best_set,
   output logic signed [bps_pkg::SCORE_W-1:0]     rsp_best_score,
   output logic                                   rsp_last_of_run
);

   localparam int DATA_W = bps_pkg::SCORE_W + IDX_W;

   bps_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]            ps_ff, ps_in;
   logic                        last_ff, last_in;
   logic [IDX_W-1:0]            rem_ff, rem_in;
   logic                        pend_ff, pend_in;
   logic [bps_pkg::SCORE_W-1:0] score_ff, score_in;
   logic [IDX_W-1:0]            best_ff, best_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_load;
   logic [IDX_W-1:0]            rsp_idx_ff;
   logic [IDX_W-1:0]            rsp_best_ff;
   logic [bps_pkg::SCORE_W-1:0] rsp_score_ff;
   logic                        rsp_last_ff;

   logic                        wr_en;
   logic                        rd_en;
   logic [IDX_W-1:0]            rd_addr;
   logic [DATA_W-1:0]           rd_data;
   logic [bps_pkg::SCORE_W-1:0] rd_score;
   logic [IDX_W-1:0]            rd_best;
   logic [IDX_W-1:0]            low_bit;
   logic                        accept;
   logic                        slot_free;

   assign rd_score = rd_data[DATA_W-1 -: bps_pkg::SCORE_W];
   assign rd_best  = rd_data[IDX_W-1:0];
   assign low_bit  = rem_ff & (~rem_ff + IDX_W'(1));
   assign rd_addr  = ps_ff ^ low_bit;
   assign accept   = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   bps_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ps_ff),
      .wr_data ({score_ff, best_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bps_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ps_ff    <= ps_in;
      last_ff  <= last_in;
      rem_ff   <= rem_in;
      score_ff <= score_in;
      best_ff  <= best_in;
      if (rsp_load) begin
         rsp_idx_ff   <= ps_ff;
         rsp_best_ff  <= best_ff;
         rsp_score_ff <= score_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ps_in     = ps_ff;
      last_in   = last_ff;
      rem_in    = rem_ff;
      pend_in   = 1'b0;
      score_in  = score_ff;
      best_in   = best_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         bps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ps_in    = set_ps;
               last_in  = set_last;
               rem_in   = set_ps;
               score_in = req_local_score;
               best_in  = set_ps;
               state_in = bps_pkg::ST_SCAN;
            end
         end
         bps_pkg::ST_SCAN: begin
            // fold in the subset read last cycle; ties go to the subset
            if (pend_ff && ($signed(rd_score) >= $signed(score_ff))) begin
               score_in = rd_score;
               best_in  = rd_best;
            end
            if (rem_ff != '0) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               rem_in  = rem_ff & ~low_bit;
            end else begin
               state_in = bps_pkg::ST_DONE;
            end
         end
         bps_pkg::ST_DONE: begin
            // hold until the result register can take the beat
            if (slot_free) begin
               wr_en    = 1'b1;
               rsp_load = 1'b1;
               state_in = bps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bps_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   generate
      if (IDX_W >= bps_pkg::OUT_IDX_W) begin : g_trunc
         assign rsp_set_index = rsp_idx_ff[bps_pkg::OUT_IDX_W-1:0];
         assign rsp_best_set  = rsp_best_ff[bps_pkg::OUT_IDX_W-1:0];
      end else begin : g_ext
         assign rsp_set_index = {{(bps_pkg::OUT_IDX_W-IDX_W){1'b0}}, rsp_idx_ff};
         assign rsp_best_set  = {{(bps_pkg::OUT_IDX_W-IDX_W){1'b0}}, rsp_best_ff};
      end
   endgenerate

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_score  = rsp_score_ff;
   assign rsp_last_of_run = rsp_last_ff;

`ifndef SYNTHESIS
   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == bps_pkg::ST_SCAN)
      else $error("read data pending outside scan");

   a_write_in_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bps_pkg::ST_DONE && slot_free))
      else $error("store write outside done state");

   a_read_is_subset: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_addr != ps_ff && (rd_addr & ~ps_ff) == '0))
      else $error("read address is not a proper subset");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == bps_pkg::ST_SCAN && !pend_ff))
      else $error("accepted beat did not start a scan");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result loaded without valid");
`endif

endmodule

// ===== design/best_parent_subset_max.sv =====
// A request beat goes from idle to the scan, one read per set bit of set_index, then to
// the done state, which waits for the result register; new beats are taken only in idle.
// The single read port of the best store serves one subset per cycle.
// Reset (synchronous): set counter to 0, vars_in_use to 16, result channel empty.
//   The best store is not cleared; every read hits an entry written earlier in the run.
// ---------------------------------------------------------------------------
// best_parent_subset_max: best parent set over the subset lattice
// Holds vars_in_use and the run counter, clamps vars_in_use to 1..MAX_VARS, restarts
// an out-of-range counter at zero and hands each request to the scan core.
// ---------------------------------------------------------------------------
module best_parent_subset_max #(
   parameter int MAX_VARS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [bps_pkg::VARS_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [bps_pkg::SCORE_W-1:0] req_local_score,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bps_pkg::OUT_IDX_W-1:0]      rsp_set_index,
   output logic [bps_pkg::OUT_IDX_W-1:0]      rsp_best_set,
   output logic signed [bps_pkg::SCORE_W-1:0] rsp_best_score,
   output logic                               rsp_last_of_run
);

   localparam int IDX_W = (MAX_VARS > 1) ? MAX_VARS - 1 : 1;

   logic [bps_pkg::VARS_W-1:0] vars_ff, vars_in;
   logic [bps_pkg::VARS_W-1:0] vars_eff;
   logic [IDX_W-1:0]           cnt_ff, cnt_in;
   logic [IDX_W-1:0]           last_mask;
   logic [IDX_W-1:0]           ps_eff;
   logic                       ps_last;
   logic                       accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      if (vars_ff == '0) begin
         vars_eff = bps_pkg::VARS_W'(1);
      end else if (vars_ff > bps_pkg::VARS_W'(MAX_VARS)) begin
         vars_eff = bps_pkg::VARS_W'(MAX_VARS);
      end else begin
         vars_eff = vars_ff;
      end
   end

   // index of the last set in the run: the low vars_eff-1 bits all ones
   always_comb begin
      for (int i = 0; i < IDX_W; i++) begin
         last_mask[i] = (bps_pkg::VARS_W'(i + 1) < vars_eff);
      end
   end

   // restart at zero when a shrunk run leaves the counter out of range
   assign ps_eff  = ((cnt_ff & ~last_mask) != '0) ? '0 : cnt_ff;
   assign ps_last = (ps_eff == last_mask);

   always_comb begin
      vars_in = csr_wr_en ? csr_wr_data : vars_ff;
      if (accept) begin
         cnt_in = ps_last ? '0 : ps_eff + IDX_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_ff <= bps_pkg::VARS_RESET;
         cnt_ff  <= '0;
      end else begin
         vars_ff <= vars_in;
         cnt_ff  <= cnt_in;
      end
   end

   bps_core #(
      .IDX_W (IDX_W)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_local_score (req_local_score),
      .set_ps          (ps_eff),
      .set_last        (ps_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_set_index   (rsp_set_index),
      .rsp_best_set    (rsp_best_set),
      .rsp_best_score  (rsp_best_score),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
